// File: design/mpra_pkg.sv
// Shared constants, types and helpers of the middle-product accumulator.
`timescale 1ns / 1ps
`default_nettype none

package mpra_pkg;

   localparam int MAX_TAPS     = 64;
   localparam int DIGIT_W      = 52;
   localparam int HALF_W       = DIGIT_W / 2;
   localparam int PROD_W       = 2 * DIGIT_W;
   localparam int TERM_W       = DIGIT_W + 1;
   localparam int SUM_W        = 59;
   localparam int POS_W        = 16;
   localparam int TAP_CNT_W    = 7;
   localparam int TAP_IDX_W    = 6;

   // tap store and tap counter
   localparam int TAP_AW       = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CNT_W        = $clog2(MAX_TAPS + 1);

   // digit history: ring buffer, power-of-two deep, MAX_TAPS+1 live entries
   localparam int HIST_ENTRIES = MAX_TAPS + 1;
   localparam int HIST_AW      = $clog2(HIST_ENTRIES);
   localparam int HIST_DEPTH   = 2 ** HIST_AW;
   localparam int FILL_W       = $clog2(HIST_ENTRIES + 1);

   // register file
   localparam int CSR_AW       = 3;
   localparam int CSR_DW       = 32;
   localparam logic [0:0] REG_TAP_COUNT = 1'b0;

   localparam logic CMD_TAP_WRITE = 1'b0;
   localparam logic CMD_PUSH      = 1'b1;

   typedef logic [DIGIT_W-1:0]   digit_type;
   typedef logic [TAP_IDX_W-1:0] tap_idx_type;
   typedef logic [SUM_W-1:0]     sum_type;
   typedef logic [POS_W-1:0]     pos_type;
   typedef logic [TERM_W-1:0]    term_type;

   // tag travelling with each tap through the multiplier pipeline
   typedef struct packed {
      logic valid;
      logic last;
   } tag_type;

   // tap count as used: zero acts as one, above MAX_TAPS clamps
   function automatic logic [CNT_W-1:0] eff_taps(input logic [TAP_CNT_W-1:0] cnt);
      logic [CNT_W-1:0] res;
      if (cnt == '0) begin
         res = CNT_W'(1);
      end else if (32'(cnt) > MAX_TAPS) begin
         res = CNT_W'(MAX_TAPS);
      end else begin
         res = CNT_W'(cnt);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: design/mpra_if.sv
// Word channels of the middle-product accumulator: request and response.
`timescale 1ns / 1ps
`default_nettype none

interface mpra_req_if;
   logic                    valid;
   logic                    ready;
   logic                    cmd;
   mpra_pkg::digit_type     digit;
   mpra_pkg::tap_idx_type   tap_index;
   logic                    new_operand;

   modport source (output valid, cmd, digit, tap_index, new_operand, input ready);
   modport sink   (input valid, cmd, digit, tap_index, new_operand, output ready);
endinterface

interface mpra_rsp_if;
   logic                    valid;
   logic                    ready;
   mpra_pkg::sum_type       raw_sum;
   mpra_pkg::pos_type       output_index;

   modport source (output valid, raw_sum, output_index, input ready);
   modport sink   (input valid, raw_sum, output_index, output ready);
endinterface

`default_nettype wire

// File: design/middle_product_radix52_accumulator.sv
// Top level: middle-product digit accumulator in radix 2^52.
// A push that yields a sum puts it on rsp once its n taps have passed the memory reads,
//   the multiplier pair and the accumulator, n being the effective tap count (1..MAX_TAPS).
// A summing push keeps req.ready low until its sum is delivered, the single multiplier pair
//   walking the tap store and the history ring one tap per cycle.
// Reset (synchronous, active high): tap_count to 1, history empty, position 0,
//   no word in flight. The tap store holds garbage until written; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module middle_product_radix52_accumulator (
   input  wire logic                          clock,
   input  wire logic                          reset,
   mpra_req_if.sink                           req,
   mpra_rsp_if.source                         rsp,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [mpra_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [mpra_pkg::CSR_DW-1:0]   csr_pwdata,
   output      logic [mpra_pkg::CSR_DW-1:0]   csr_prdata,
   output      logic                          csr_pready
);

   localparam int CNT_W   = mpra_pkg::CNT_W;
   localparam int HIST_AW = mpra_pkg::HIST_AW;
   localparam int FILL_W  = mpra_pkg::FILL_W;
   localparam int POS_W   = mpra_pkg::POS_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_DELIVER
   } state_type;

   // ---------------------------------------------------------------- csr
   logic [mpra_pkg::TAP_CNT_W-1:0] tap_count_ff, tap_count_in;
   logic                           csr_wr;
   logic                           csr_sel_tc;

   assign csr_pready = 1'b1;
   assign csr_sel_tc = (csr_paddr[mpra_pkg::CSR_AW-1] == mpra_pkg::REG_TAP_COUNT);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_sel_tc ? mpra_pkg::CSR_DW'(tap_count_ff) : '0;

   // ---------------------------------------------------------------- state
   state_type                state_ff, state_in;
   logic [HIST_AW-1:0]       head_ff, head_in;      // ring slot of the newest digit
   logic [FILL_W-1:0]        fill_ff, fill_in;      // live digits in the ring
   mpra_pkg::pos_type        pos_ff, pos_in;        // position of the next push
   logic [CNT_W-1:0]         n_ff, n_in;            // taps for the sum in flight
   logic [CNT_W-1:0]         t_ff, t_in;            // tap being issued
   mpra_pkg::pos_type        k_ff, k_in;            // band index of the sum in flight
   mpra_pkg::sum_type        acc_ff, acc_in;
   mpra_pkg::tag_type        iss_tag_ff, iss_tag_in;
   logic                     keep0_ff, keep0_in, keep1_ff, keep1_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   mpra_pkg::sum_type        rsp_sum_ff, rsp_sum_in;
   mpra_pkg::pos_type        rsp_index_ff, rsp_index_in;

   // ---------------------------------------------------------------- memories
   logic                     tap_we;
   logic [mpra_pkg::TAP_AW-1:0] tap_waddr, tap_raddr;
   mpra_pkg::digit_type      tap_rdata;
   logic                     hist_we;
   logic [HIST_AW-1:0]       hist_waddr, hist_raddr0, hist_raddr1;
   mpra_pkg::digit_type      hist_rdata0, hist_rdata1;

   // pipeline outputs
   mpra_pkg::digit_type      mul_y0, mul_y1;
   mpra_pkg::tag_type        term_tag;
   mpra_pkg::term_type       term;

   // push bookkeeping
   logic                     accept;
   mpra_pkg::pos_type        pos_cur;
   logic [CNT_W-1:0]         n_eff;
   logic                     emits;
   logic                     last_tap;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;

   assign n_eff     = mpra_pkg::eff_taps(tap_count_ff);
   assign pos_cur   = req.new_operand ? '0 : pos_ff;
   // a sum is due once the band is fully covered: p+1 >= n
   assign emits     = ((POS_W + 1)'(pos_cur) + (POS_W + 1)'(1)) >= (POS_W + 1)'(n_eff);
   assign last_tap  = (t_ff == n_ff - CNT_W'(1));

   // tap store written straight from the request word
   assign tap_we    = accept && (req.cmd == mpra_pkg::CMD_TAP_WRITE)
                      && (32'(req.tap_index) < mpra_pkg::MAX_TAPS);
   assign tap_waddr = mpra_pkg::TAP_AW'(req.tap_index);
   assign tap_raddr = mpra_pkg::TAP_AW'(t_ff);

   // ring: newest digit at head, age a at head-a; both banks take every push
   assign hist_we     = accept && (req.cmd == mpra_pkg::CMD_PUSH);
   assign hist_waddr  = head_ff + HIST_AW'(1);
   assign hist_raddr0 = head_ff - HIST_AW'(t_ff);
   assign hist_raddr1 = hist_raddr0 - HIST_AW'(1);

   mpra_ram #(
      .WIDTH (mpra_pkg::DIGIT_W),
      .DEPTH (mpra_pkg::MAX_TAPS)
   ) u_tap_ram (
      .clock   (clock),
      .wr_en   (tap_we),
      .wr_addr (tap_waddr),
      .wr_data (req.digit),
      .rd_addr (tap_raddr),
      .rd_data (tap_rdata)
   );

   // two identical banks give the history two reads a cycle: age t and age t+1
   mpra_ram #(
      .WIDTH (mpra_pkg::DIGIT_W),
      .DEPTH (mpra_pkg::HIST_DEPTH)
   ) u_hist_ram0 (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (req.digit),
      .rd_addr (hist_raddr0),
      .rd_data (hist_rdata0)
   );

   mpra_ram #(
      .WIDTH (mpra_pkg::DIGIT_W),
      .DEPTH (mpra_pkg::HIST_DEPTH)
   ) u_hist_ram1 (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (req.digit),
      .rd_addr (hist_raddr1),
      .rd_data (hist_rdata1)
   );

   // slots past the fill count are stale or unwritten: they read as zero
   assign mul_y0 = keep0_ff ? hist_rdata0 : '0;
   assign mul_y1 = keep1_ff ? hist_rdata1 : '0;

   mpra_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .tag_in  (iss_tag_ff),
      .x       (tap_rdata),
      .y0      (mul_y0),
      .y1      (mul_y1),
      .tag_out (term_tag),
      .term    (term)
   );

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      pos_in       = pos_ff;
      n_in         = n_ff;
      t_in         = t_ff;
      k_in         = k_ff;
      acc_in       = acc_ff;
      iss_tag_in   = '0;
      keep0_in     = 1'b0;
      keep1_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_sum_in   = rsp_sum_ff;
      rsp_index_in = rsp_index_ff;
      tap_count_in = tap_count_ff;

      if (csr_wr && csr_sel_tc) begin
         tap_count_in = csr_pwdata[mpra_pkg::TAP_CNT_W-1:0];
      end

      // partial sums land whenever the pipeline hands one over
      if (term_tag.valid) begin
         acc_in = acc_ff + mpra_pkg::SUM_W'(term);
         if (term_tag.last) begin
            state_in = ST_DELIVER;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req.cmd == mpra_pkg::CMD_PUSH)) begin
               head_in = hist_waddr;
               if (req.new_operand) begin
                  fill_in = FILL_W'(1);
               end else if (32'(fill_ff) < mpra_pkg::HIST_ENTRIES) begin
                  fill_in = fill_ff + FILL_W'(1);
               end
               pos_in = (pos_cur == '1) ? pos_cur : pos_cur + POS_W'(1);
               n_in   = n_eff;
               t_in   = '0;
               k_in   = pos_cur - POS_W'(n_eff) + POS_W'(1);
               acc_in = '0;
               if (emits) begin
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            iss_tag_in.valid = 1'b1;
            iss_tag_in.last  = last_tap;
            keep0_in         = (FILL_W'(t_ff) < fill_ff);
            keep1_in         = ((FILL_W'(t_ff) + FILL_W'(1)) < fill_ff);
            t_in             = t_ff + CNT_W'(1);
            if (last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // waiting for the last term; handled above
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = acc_ff;
               rsp_index_in = k_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         pos_ff       <= '0;
         t_ff         <= '0;
         iss_tag_ff   <= '0;
         keep0_ff     <= 1'b0;
         keep1_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tap_count_ff <= mpra_pkg::TAP_CNT_W'(1);
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         pos_ff       <= pos_in;
         t_ff         <= t_in;
         iss_tag_ff   <= iss_tag_in;
         keep0_ff     <= keep0_in;
         keep1_ff     <= keep1_in;
         rsp_valid_ff <= rsp_valid_in;
         tap_count_ff <= tap_count_in;
      end
      n_ff         <= n_in;
      k_ff         <= k_in;
      acc_ff       <= acc_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.raw_sum      = rsp_sum_ff;
   assign rsp.output_index = rsp_index_ff;

   // ---------------------------------------------------------------- checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= mpra_pkg::HIST_ENTRIES)
      else $error("history fill count beyond ring size");

   a_issue_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) |-> (t_ff < n_ff))
      else $error("tap issue ran past tap count");

   a_last_delivers: assert property (@(posedge clock) disable iff (reset)
      (term_tag.valid && term_tag.last) |=> (state_ff == ST_DELIVER))
      else $error("final term did not move to delivery");

   a_term_busy: assert property (@(posedge clock) disable iff (reset)
      term_tag.valid |-> (state_ff != ST_IDLE))
      else $error("term arrived with no sum in flight");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DELIVER))
      else $error("response raised outside delivery");

endmodule

`default_nettype wire

// File: design/mpra_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mpra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/mpra_mul.sv
// Three-stage multiplier pair: lo52(x*y0) + hi52(x*y1) from 26x26 partials.
`timescale 1ns / 1ps
`default_nettype none

module mpra_mul (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mpra_pkg::tag_type   tag_in,
   input  wire mpra_pkg::digit_type x,
   input  wire mpra_pkg::digit_type y0,
   input  wire mpra_pkg::digit_type y1,
   output      mpra_pkg::tag_type   tag_out,
   output      mpra_pkg::term_type  term
);

   localparam int HW = mpra_pkg::HALF_W;
   localparam int PW = 2 * mpra_pkg::HALF_W;
   localparam int DW = mpra_pkg::DIGIT_W;

   // partial products: [0] lo*lo, [1] lo*hi, [2] hi*lo, [3] hi*hi
   logic [PW-1:0] pa_ff [4];
   logic [PW-1:0] pb_ff [4];
   logic [PW-1:0] pa_in [4];
   logic [PW-1:0] pb_in [4];
   logic [mpra_pkg::PROD_W-1:0] prod_a_ff, prod_b_ff, prod_a_in, prod_b_in;
   mpra_pkg::term_type term_ff, term_in;
   mpra_pkg::tag_type  tag1_ff, tag2_ff, tag3_ff;

   always_comb begin
      pa_in[0] = PW'(x[HW-1:0])  * PW'(y0[HW-1:0]);
      pa_in[1] = PW'(x[HW-1:0])  * PW'(y0[DW-1:HW]);
      pa_in[2] = PW'(x[DW-1:HW]) * PW'(y0[HW-1:0]);
      pa_in[3] = PW'(x[DW-1:HW]) * PW'(y0[DW-1:HW]);
      pb_in[0] = PW'(x[HW-1:0])  * PW'(y1[HW-1:0]);
      pb_in[1] = PW'(x[HW-1:0])  * PW'(y1[DW-1:HW]);
      pb_in[2] = PW'(x[DW-1:HW]) * PW'(y1[HW-1:0]);
      pb_in[3] = PW'(x[DW-1:HW]) * PW'(y1[DW-1:HW]);
   end

   always_comb begin
      prod_a_in = mpra_pkg::PROD_W'(pa_ff[0])
                + (mpra_pkg::PROD_W'(pa_ff[1]) << HW)
                + (mpra_pkg::PROD_W'(pa_ff[2]) << HW)
                + (mpra_pkg::PROD_W'(pa_ff[3]) << PW);
      prod_b_in = mpra_pkg::PROD_W'(pb_ff[0])
                + (mpra_pkg::PROD_W'(pb_ff[1]) << HW)
                + (mpra_pkg::PROD_W'(pb_ff[2]) << HW)
                + (mpra_pkg::PROD_W'(pb_ff[3]) << PW);
      term_in   = mpra_pkg::TERM_W'(prod_a_ff[DW-1:0])
                + mpra_pkg::TERM_W'(prod_b_ff[mpra_pkg::PROD_W-1:DW]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag1_ff <= tag_in;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
      pa_ff     <= pa_in;
      pb_ff     <= pb_in;
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      term_ff   <= term_in;
   end

   assign tag_out = tag3_ff;
   assign term    = term_ff;

endmodule

`default_nettype wire

// File: bench/tb_middle_product_radix52_accumulator.sv
// Self-checking bench for the radix 2^52 middle-product accumulator.
`timescale 1ns / 1ps

module tb_middle_product_radix52_accumulator;
   import mpra_pkg::*;

   // ---------------------------------------------------------------------
   // Bench constants
   // ---------------------------------------------------------------------
   localparam int          RESET_CYCLES = 12;
   // A busy push holds the block until its sum goes out; allow the widest tap count plus slack
   // before touching the register after the last word went in.
   localparam int          SETTLE_CYCLES = MAX_TAPS + 16;
   // Cycles without any handshake before the run is declared hung.
   localparam int          STALL_LIMIT = 2000;
   localparam int unsigned POS_CEILING = 65535;
   // Digits streamed into the single-tap operand of the long-operand test.
   localparam int          LONG_PUSHES = 24;
   localparam logic [CSR_AW-1:0] TAP_COUNT_ADDR = CSR_AW'(4 * REG_TAP_COUNT);

   // One expected output word: the sum and its band position.
   typedef struct packed {
      sum_type raw_sum;
      pos_type output_index;
   } band_sum_type;

   // ---------------------------------------------------------------------
   // Clock, reset, channels, register port
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset;

   always #5ns clock = ~clock;

   mpra_req_if req();
   mpra_rsp_if rsp();

   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CSR_AW-1:0]   csr_paddr;
   logic [CSR_DW-1:0]   csr_pwdata;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   middle_product_radix52_accumulator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ---------------------------------------------------------------------
   // Bench-side copy of the block state
   // ---------------------------------------------------------------------
   digit_type      mult_taps [MAX_TAPS];     // multiplier digits
   logic           tap_loaded [MAX_TAPS];    // tap written since reset
   digit_type      operand_hist [MAX_TAPS+1]; // index 0 = newest digit
   int unsigned    digit_pos;                // position of the next push
   logic [TAP_CNT_W-1:0] tap_count_reg;

   band_sum_type   band_sums [$];            // sums still to come out

   int unsigned    send_idle_pct;
   int unsigned    recv_idle_pct;
   int unsigned    words_sent;
   int unsigned    sums_checked;
   int unsigned    mismatches;
   int unsigned    stall_cycles;

   // Tap count as the block uses it: zero means one, anything above the
   // store size means the full store.
   function automatic int unsigned taps_in_use(input logic [TAP_CNT_W-1:0] cnt);
      if (cnt == '0) return 1;
      if (int'(cnt) > MAX_TAPS) return MAX_TAPS;
      return int'(cnt);
   endfunction

   // Apply one accepted word to the bench state and queue the band sum it
   // produces, if any.
   task automatic middle_product_step(input logic c, input digit_type d,
                                      input tap_idx_type ti, input logic fresh);
      band_sum_type s;
      int unsigned  n;
      int unsigned  p;
      logic [63:0]  acc;
      logic [2*DIGIT_W-1:0] prod;
      if (c == CMD_TAP_WRITE) begin
         // new_operand plays no part in a tap write
         if (int'(ti) < MAX_TAPS) begin
            mult_taps[ti]  = d;
            tap_loaded[ti] = 1'b1;
         end
         return;
      end
      if (fresh) begin
         foreach (operand_hist[i]) operand_hist[i] = '0;
         digit_pos = 0;
      end
      for (int i = MAX_TAPS; i > 0; i--) operand_hist[i] = operand_hist[i-1];
      operand_hist[0] = d;
      p = digit_pos;
      if (digit_pos < POS_CEILING) digit_pos++;
      n = taps_in_use(tap_count_reg);
      if (p + 1 < n) return;              // band not yet reached
      acc = '0;
      for (int t = 0; t < n; t++) begin
         // low half of b[t]*a[p-t], high half of b[t]*a[p-1-t]
         prod = (2*DIGIT_W)'(mult_taps[t]) * (2*DIGIT_W)'(operand_hist[t]);
         acc += 64'(prod[DIGIT_W-1:0]);
         prod = (2*DIGIT_W)'(mult_taps[t]) * (2*DIGIT_W)'(operand_hist[t+1]);
         acc += 64'(prod[2*DIGIT_W-1:DIGIT_W]);
      end
      s.raw_sum      = acc[SUM_W-1:0];
      s.output_index = POS_W'(p - (n - 1));
      band_sums.push_back(s);
   endtask

   // ---------------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------------
   // Present one word; valid is left high on return so back-to-back words
   // need no extra edge.
   task automatic send_word(input logic c, input digit_type d,
                            input tap_idx_type ti, input logic fresh);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.cmd         <= c;
      req.digit       <= d;
      req.tap_index   <= ti;
      req.new_operand <= fresh;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      middle_product_step(c, d, ti, fresh);
      words_sent++;
   endtask

   // Hold the sender off until every queued sum has been seen.
   task automatic drain_sums();
      req.valid <= 1'b0;
      @(posedge clock);
      while (band_sums.size() != 0) @(posedge clock);
   endtask

   // Drain, then let a tap write or early push still in flight finish.
   task automatic settle();
      drain_sums();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write of tap_count: setup then access, pready is always high.
   task automatic write_tap_count(input logic [TAP_CNT_W-1:0] cnt);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= TAP_COUNT_ADDR;
      csr_pwdata  <= CSR_DW'(cnt);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      tap_count_reg = cnt;
   endtask

   function automatic digit_type rand_digit();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return r[DIGIT_W-1:0];
      endcase
   endfunction

   // Mostly short multipliers; the extremes and the full store now and then.
   function automatic logic [TAP_CNT_W-1:0] pick_tap_count();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 5)  return '0;
      if (r < 10) return '1;
      if (r < 16) return TAP_CNT_W'(MAX_TAPS);
      if (r < 32) return TAP_CNT_W'($urandom_range(9, MAX_TAPS - 1));
      return TAP_CNT_W'($urandom_range(1, 8));
   endfunction

   // ---------------------------------------------------------------------
   // Result checking and receiver back-pressure
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      band_sum_type exp_sum;
      if (!reset && rsp.valid && rsp.ready) begin
         if (band_sums.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected word raw_sum=%h output_index=%0d",
                     $time, rsp.raw_sum, rsp.output_index);
         end else begin
            exp_sum = band_sums.pop_front();
            sums_checked++;
            if (rsp.raw_sum !== exp_sum.raw_sum
                || rsp.output_index !== exp_sum.output_index) begin
               mismatches++;
               $display("%0t: mismatch expected raw_sum=%h index=%0d, got raw_sum=%h index=%0d",
                        $time, exp_sum.raw_sum, exp_sum.output_index,
                        rsp.raw_sum, rsp.output_index);
            end
         end
      end
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: any handshake restarts the count.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles == STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Digit extremes, ignored fields, a tap change mid-stream, an early
   // position after a fresh operand and a zero tap count.
   task automatic test_directed();
      digit_type ones;
      digit_type alt;
      ones = '1;
      alt  = {13{4'h5}};
      send_word(CMD_TAP_WRITE, ones, 6'd0, 1'b1);    // new_operand ignored
      send_word(CMD_TAP_WRITE, '0, 6'd63, 1'b0);     // top tap index
      send_word(CMD_PUSH, ones, 6'd0, 1'b1);
      send_word(CMD_PUSH, '0, 6'd0, 1'b0);
      send_word(CMD_PUSH, ones, 6'd63, 1'b0);        // tap_index ignored
      send_word(CMD_PUSH, alt, 6'd21, 1'b0);
      settle();
      write_tap_count(TAP_CNT_W'(2));
      send_word(CMD_TAP_WRITE, ones, 6'd1, 1'b0);
      send_word(CMD_PUSH, ~alt, 6'd0, 1'b0);         // stream carries on at n=2
      send_word(CMD_PUSH, ones, 6'd0, 1'b1);         // position 0: no sum
      send_word(CMD_PUSH, ones, 6'd42, 1'b0);
      send_word(CMD_TAP_WRITE, DIGIT_W'(1), 6'd0, 1'b0);
      send_word(CMD_PUSH, '0, 6'd0, 1'b0);
      settle();
      write_tap_count('0);                           // behaves as one tap
      send_word(CMD_PUSH, ones, 6'd0, 1'b0);
      send_word(CMD_PUSH, DIGIT_W'(1), 6'd0, 1'b1);
   endtask

   // Phases of: new tap count, multiplier load, then a few operands with
   // random content, sprinkled with stray tap writes and pauses.
   task automatic test_random_traffic(input int unsigned target,
                                      input logic [TAP_CNT_W-1:0] first_count);
      int unsigned          start;
      int unsigned          n;
      int unsigned          len;
      logic [TAP_CNT_W-1:0] cnt;
      logic                 first;
      start = words_sent;
      first = 1'b1;
      while (words_sent - start < target) begin
         cnt   = first ? first_count : pick_tap_count();
         first = 1'b0;
         settle();
         write_tap_count(cnt);
         n = taps_in_use(cnt);
         for (int t = 0; t < n; t++) begin
            if (!tap_loaded[t] || $urandom_range(1))
               send_word(CMD_TAP_WRITE, rand_digit(), tap_idx_type'(t),
                         1'($urandom_range(1)));
         end
         repeat ($urandom_range(1, 3)) begin
            len = $urandom_range(1, (n > 16) ? n + 8 : 2 * n + 6);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(19) == 0)
                  send_word(CMD_TAP_WRITE, rand_digit(),
                            tap_idx_type'($urandom_range(MAX_TAPS - 1)),
                            1'($urandom_range(1)));
               if ($urandom_range(49) == 0) drain_sums();
               // first word of an operand usually restarts the position
               send_word(CMD_PUSH, rand_digit(), tap_idx_type'($urandom),
                         (k == 0) ? ($urandom_range(9) != 0)
                                  : ($urandom_range(29) == 0));
            end
         end
      end
   endtask

   // Stream a long single-tap operand, retune the tap count part-way
   // through it, then restart with a fresh operand.
   task automatic test_long_operand();
      settle();
      write_tap_count(TAP_CNT_W'(1));
      send_word(CMD_TAP_WRITE, rand_digit(), 6'd0, 1'b0);
      send_word(CMD_PUSH, rand_digit(), 6'd0, 1'b1);
      repeat (LONG_PUSHES) send_word(CMD_PUSH, rand_digit(), 6'd0, 1'b0);
      settle();
      write_tap_count(TAP_CNT_W'(3));
      for (int t = 0; t < 3; t++)
         send_word(CMD_TAP_WRITE, rand_digit(), tap_idx_type'(t), 1'b0);
      repeat (4) send_word(CMD_PUSH, rand_digit(), 6'd0, 1'b0);
      send_word(CMD_PUSH, rand_digit(), 6'd0, 1'b1);
      repeat (4) send_word(CMD_PUSH, rand_digit(), 6'd0, 1'b0);
   endtask

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      req.valid       = 1'b0;
      req.cmd         = CMD_TAP_WRITE;
      req.digit       = '0;
      req.tap_index   = '0;
      req.new_operand = 1'b0;
      rsp.ready       = 1'b0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      // bench state after reset; taps stay unloaded until written
      foreach (mult_taps[i]) begin
         mult_taps[i]  = '0;
         tap_loaded[i] = 1'b0;
      end
      foreach (operand_hist[i]) operand_hist[i] = '0;
      digit_pos     = 0;
      tap_count_reg = TAP_CNT_W'(1);
      words_sent    = 0;
      sums_checked  = 0;
      mismatches    = 0;
      stall_cycles  = 0;
      send_idle_pct = 37;
      recv_idle_pct = 79;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_traffic(200, TAP_CNT_W'(MAX_TAPS));

      send_idle_pct = 79;
      recv_idle_pct = 37;
      test_random_traffic(200, '1);                   // clamps to the full store

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(200, pick_tap_count());
      test_long_operand();

      // wait-out: all sums in, then look for strays
      drain_sums();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d words and %0d band sums, tap counts from zero to 127,",
               words_sent, sums_checked);
      $display("mid-stream retuning, early positions and a long single-tap operand");
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: middle_product_radix52_accumulator.f
design/mpra_pkg.sv
design/mpra_if.sv
design/mpra_ram.sv
design/mpra_mul.sv
design/middle_product_radix52_accumulator.sv
bench/tb_middle_product_radix52_accumulator.sv
